// File: sv/sensor_response_frame_receiver_macros.svh
// assertion macros for the sensor response frame receiver
`ifndef SENSOR_RESPONSE_FRAME_RECEIVER_MACROS_SVH
`define SENSOR_RESPONSE_FRAME_RECEIVER_MACROS_SVH
`ifndef ASSERT_OFF
`define SRFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SRFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SRFR_ASSERT(lbl, prop, msg)
`define SRFR_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: sv/srfr_pkg.sv
// constants and types shared by the frame receiver
package srfr_pkg;

  localparam int RESP_DATA_BYTES = 14;
  localparam int FRAME_BUF_BYTES = 1024;

  // payload count and byte counter width
  localparam int PLEN_W = ($clog2(FRAME_BUF_BYTES) > 7) ? $clog2(FRAME_BUF_BYTES) : 7;
  localparam int LEN_OUT_W = 10;

  localparam logic [7:0] PFX_RESP_0 = 8'hAA;
  localparam logic [7:0] PFX_RESP_1 = 8'h55;
  localparam logic [7:0] PFX_DATA_0 = 8'hA5;
  localparam logic [7:0] PFX_DATA_1 = 8'h5A;
  localparam logic [15:0] SUM_INIT  = 16'h00FF;

  localparam bit RESP_TOO_BIG = (RESP_DATA_BYTES + 2) > FRAME_BUF_BYTES;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CODE     = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_DEVICE   = 3'd4
  } status_e;

  localparam logic KIND_RESP = 1'b0;
  localparam logic KIND_DATA = 1'b1;

endpackage

// File: sv/sensor_response_frame_receiver.sv
// sensor response frame receiver: prefix hunt, header parse, payload stream, status
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one received link byte per request.
//   Output channel (out_valid_o / out_stall_i) carries zero or one result per input
//   byte: a payload byte (payload_valid_o) or a final frame status (frame_done_o),
//   each with the header fields of the current frame.
//   cfg_we_i / cfg_wdata_i write the expected command code; zero accepts any code.
//   Each byte is processed in the cycle it is accepted and its result sits in the
//   output register in the next cycle; throughput 1 byte per cycle while in_stall_o is low,
//   with a single state update between input and result register.
//   Prefix bytes, header bytes and the checksum low byte give no result, except the
//   last header byte of a header that fails its code or length check.
//   When out_stall_i holds a waiting result, in_stall_o rises in the same cycle and
//   no byte is taken until the result is taken; nothing is dropped.
//   Reset clears the hunt, the frame state, the header store and the output valid;
//   the expected code resets to zero.
`include "sensor_response_frame_receiver_macros.svh"

module sensor_response_frame_receiver
  import srfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic        frame_done_o,
  output logic        frame_kind_o,
  output logic [2:0]  status_o,
  output logic [15:0] return_code_o,
  output logic [15:0] command_code_o,
  output logic [7:0]  source_id_o,
  output logic [7:0]  dest_id_o,
  output logic [9:0]  payload_length_o
);

  typedef enum logic [1:0] {
    H_IDLE = 2'd0,
    H_AA   = 2'd1,
    H_A5   = 2'd2
  } hunt_e;

  typedef enum logic [1:0] {
    F_HUNT    = 2'd0,
    F_HEADER  = 2'd1,
    F_PAYLOAD = 2'd2,
    F_CHECK   = 2'd3
  } frame_e;

  hunt_e             hunt_q, hunt_d;
  frame_e            frame_q, frame_d;
  logic [PLEN_W-1:0] cnt_q, cnt_d;
  logic [PLEN_W-1:0] plen_q, plen_d;
  logic [15:0]       sum_q, sum_d;
  logic [63:0]       hdr_q, hdr_d;
  logic [7:0]        chk_lo_q, chk_lo_d;
  logic              kind_q, kind_d;
  logic [15:0]       expected_q;

  logic              out_valid_q;
  logic [7:0]        pbyte_q;
  logic              pvalid_q, done_q, okind_q;
  status_e           status_q;
  logic [15:0]       ret_q, cmd_q;
  logic [7:0]        src_q, dst_q;
  logic [9:0]        olen_q;

  logic              res;
  logic [7:0]        r_pbyte;
  logic              r_pvalid, r_done;
  status_e           r_status;
  logic [PLEN_W-1:0] r_plen;
  logic [31:0]       r_plen_ext;

  logic              in_acc;
  logic [7:0]        b;
  logic [15:0]       len_word, len_m2;
  logic [PLEN_W:0]   cnt_inc;
  logic              len_bad;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign b          = rx_byte_i;
  assign len_word   = hdr_q[47:32];
  assign len_m2     = len_word - 16'd2;
  assign cnt_inc    = {1'b0, cnt_q} + {{PLEN_W{1'b0}}, 1'b1};
  assign r_plen_ext = {{(32-PLEN_W){1'b0}}, r_plen};

  always_comb begin
    hunt_d   = hunt_q;
    frame_d  = frame_q;
    cnt_d    = cnt_q;
    plen_d   = plen_q;
    sum_d    = sum_q;
    hdr_d    = hdr_q;
    chk_lo_d = chk_lo_q;
    kind_d   = kind_q;
    res      = 1'b0;
    r_pbyte  = 8'd0;
    r_pvalid = 1'b0;
    r_done   = 1'b0;
    r_status = ST_OK;
    r_plen   = '0;
    len_bad  = 1'b0;
    case (frame_q)
      F_HUNT: begin
        hunt_d = (b == PFX_RESP_0) ? H_AA : (b == PFX_DATA_0) ? H_A5 : H_IDLE;
        case (hunt_q)
          H_IDLE: ;
          H_AA: begin
            if (b == PFX_RESP_1) begin
              kind_d  = KIND_RESP;
              frame_d = F_HEADER;
            end
          end
          H_A5: begin
            if (b == PFX_DATA_1) begin
              kind_d  = KIND_DATA;
              frame_d = F_HEADER;
            end
          end
          default: hunt_d = H_IDLE;
        endcase
        if (frame_d == F_HEADER) begin
          hunt_d = H_IDLE;
          cnt_d  = '0;
          hdr_d  = '0;
          sum_d  = SUM_INIT;
        end
      end
      F_HEADER: begin
        hdr_d[8*cnt_q[2:0] +: 8] = b;
        sum_d = sum_q + {8'd0, b};
        cnt_d = cnt_inc[PLEN_W-1:0];
        if (cnt_q[2:0] == 3'd7) begin
          len_bad = (kind_q == KIND_RESP) ? RESP_TOO_BIG
                  : ((len_word < 16'd2) || (len_word > 16'(FRAME_BUF_BYTES)));
          if (expected_q != 16'd0 && hdr_q[31:16] != expected_q) begin
            res      = 1'b1;
            r_done   = 1'b1;
            r_status = ST_CODE;
            frame_d  = F_HUNT;
            hunt_d   = H_IDLE;
            cnt_d    = '0;
          end else if (len_bad) begin
            res      = 1'b1;
            r_done   = 1'b1;
            r_status = ST_BAD_LEN;
            frame_d  = F_HUNT;
            hunt_d   = H_IDLE;
            cnt_d    = '0;
          end else begin
            plen_d  = (kind_q == KIND_RESP) ? PLEN_W'(RESP_DATA_BYTES)
                                            : len_m2[PLEN_W-1:0];
            cnt_d   = '0;
            frame_d = (plen_d == '0) ? F_CHECK : F_PAYLOAD;
          end
        end
      end
      F_PAYLOAD: begin
        sum_d    = sum_q + {8'd0, b};
        res      = 1'b1;
        r_pbyte  = b;
        r_pvalid = 1'b1;
        r_plen   = plen_q;
        cnt_d    = cnt_inc[PLEN_W-1:0];
        if (cnt_inc >= {1'b0, plen_q}) begin
          frame_d = F_CHECK;
          cnt_d   = '0;
        end
      end
      F_CHECK: begin
        if (cnt_q == '0) begin
          chk_lo_d = b;
          cnt_d    = {{(PLEN_W-1){1'b0}}, 1'b1};
        end else begin
          res    = 1'b1;
          r_done = 1'b1;
          r_plen = plen_q;
          if ({b, chk_lo_q} != sum_q) begin
            r_status = ST_CHECKSUM;
          end else if (hdr_q[55:48] != 8'd0) begin
            r_status = ST_DEVICE;
          end else begin
            r_status = ST_OK;
          end
          frame_d = F_HUNT;
          hunt_d  = H_IDLE;
          cnt_d   = '0;
        end
      end
      default: frame_d = F_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q      <= H_IDLE;
      frame_q     <= F_HUNT;
      cnt_q       <= '0;
      plen_q      <= '0;
      sum_q       <= '0;
      hdr_q       <= '0;
      chk_lo_q    <= '0;
      kind_q      <= KIND_RESP;
      expected_q  <= '0;
      out_valid_q <= 1'b0;
      pbyte_q     <= '0;
      pvalid_q    <= 1'b0;
      done_q      <= 1'b0;
      okind_q     <= 1'b0;
      status_q    <= ST_OK;
      ret_q       <= '0;
      cmd_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      olen_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        expected_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        hunt_q      <= hunt_d;
        frame_q     <= frame_d;
        cnt_q       <= cnt_d;
        plen_q      <= plen_d;
        sum_q       <= sum_d;
        hdr_q       <= hdr_d;
        chk_lo_q    <= chk_lo_d;
        kind_q      <= kind_d;
        out_valid_q <= res;
        if (res) begin
          pbyte_q  <= r_pbyte;
          pvalid_q <= r_pvalid;
          done_q   <= r_done;
          okind_q  <= kind_d;
          status_q <= r_status;
          ret_q    <= hdr_d[63:48];
          cmd_q    <= hdr_d[31:16];
          src_q    <= hdr_d[7:0];
          dst_q    <= hdr_d[15:8];
          olen_q   <= r_plen_ext[LEN_OUT_W-1:0];
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = pbyte_q;
  assign payload_valid_o  = pvalid_q;
  assign frame_done_o     = done_q;
  assign frame_kind_o     = okind_q;
  assign status_o         = status_q;
  assign return_code_o    = ret_q;
  assign command_code_o   = cmd_q;
  assign source_id_o      = src_q;
  assign dest_id_o        = dst_q;
  assign payload_length_o = olen_q;

  `SRFR_ASSERT_IMP(a_one_kind, out_valid_q, !(pvalid_q && done_q) && (pvalid_q || done_q),
                   "result is neither or both payload and done")
  `SRFR_ASSERT_IMP(a_payload_ok, out_valid_q && pvalid_q, status_q == ST_OK,
                   "payload result with nonzero status")
  `SRFR_ASSERT_IMP(a_stall_held, in_stall_o, out_valid_q,
                   "input stalled with no result waiting")
  `SRFR_ASSERT_IMP(a_cnt_range, frame_q == F_PAYLOAD, cnt_q < plen_q,
                   "payload counter beyond payload length")
  `SRFR_ASSERT_IMP(a_hunt_idle, frame_q != F_HUNT, hunt_q == H_IDLE,
                   "prefix hunt active inside a frame")

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the sensor response frame receiver
module testbench;
  import srfr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  localparam logic [1:0] HUNT_IDLE = 2'd0;
  localparam logic [1:0] HUNT_RESP = 2'd1;
  localparam logic [1:0] HUNT_DATA = 2'd2;

  localparam logic [1:0] PH_HUNT     = 2'd0;
  localparam logic [1:0] PH_HEADER   = 2'd1;
  localparam logic [1:0] PH_PAYLOAD  = 2'd2;
  localparam logic [1:0] PH_CHECKSUM = 2'd3;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic        frame_kind;
    logic [2:0]  status;
    logic [15:0] return_code;
    logic [15:0] command_code;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
    logic [9:0]  payload_length;
  } frame_result_t;

  class frame_scoreboard;
    frame_result_t pending_results[$];
    logic [15:0]   expected_code;
    logic [1:0]    hunt;
    logic [1:0]    phase;
    logic [15:0]   count;
    logic [15:0]   sum;
    logic [63:0]   header;
    logic [7:0]    sum_low;
    logic          kind;
    int unsigned   mismatches;

    function new();
      expected_code = '0;
      hunt = HUNT_IDLE;
      phase = PH_HUNT;
      count = '0;
      sum = '0;
      header = '0;
      sum_low = '0;
      kind = KIND_RESP;
      mismatches = 0;
    endfunction

    function logic [15:0] word_at(int i);
      return header[8*i +: 16];
    endfunction

    function logic [15:0] payload_count();
      if (kind == KIND_RESP) return 16'(RESP_DATA_BYTES);
      return word_at(4) - 16'd2;
    endfunction

    function void push_result(logic [7:0] pbyte, logic pvalid, logic done, status_e st,
                              logic [15:0] plen);
      frame_result_t r;
      r.payload_byte   = pbyte;
      r.payload_valid  = pvalid;
      r.frame_done     = done;
      r.frame_kind     = kind;
      r.status         = st;
      r.return_code    = word_at(6);
      r.command_code   = word_at(2);
      r.source_id      = header[7:0];
      r.dest_id        = header[15:8];
      r.payload_length = plen[9:0];
      pending_results.push_back(r);
    endfunction

    function void end_frame();
      phase = PH_HUNT;
      hunt  = HUNT_IDLE;
      count = '0;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [2:0]  pos;
      logic [15:0] total;
      case (phase)
        PH_HUNT: begin
          if ((hunt == HUNT_RESP && b == PFX_RESP_1) ||
              (hunt == HUNT_DATA && b == PFX_DATA_1)) begin
            kind   = (hunt == HUNT_DATA) ? KIND_DATA : KIND_RESP;
            hunt   = HUNT_IDLE;
            phase  = PH_HEADER;
            count  = '0;
            header = '0;
            sum    = SUM_INIT;
          end else if (b == PFX_RESP_0) begin
            hunt = HUNT_RESP;
          end else if (b == PFX_DATA_0) begin
            hunt = HUNT_DATA;
          end else begin
            hunt = HUNT_IDLE;
          end
        end
        PH_HEADER: begin
          pos = count[2:0];
          header[8*int'(pos) +: 8] = b;
          sum   = sum + b;
          count = count + 16'd1;
          if (pos == 3'd7) begin
            total = (kind == KIND_RESP) ? 16'(RESP_DATA_BYTES + 2) : word_at(4);
            // code check wins over the length check
            if (expected_code != 16'd0 && word_at(2) != expected_code) begin
              push_result(8'd0, 1'b0, 1'b1, ST_CODE, 16'd0);
              end_frame();
            end else if (total < 16'd2 || int'(total) > FRAME_BUF_BYTES) begin
              push_result(8'd0, 1'b0, 1'b1, ST_BAD_LEN, 16'd0);
              end_frame();
            end else begin
              count = '0;
              phase = (payload_count() == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          sum   = sum + b;
          count = count + 16'd1;
          push_result(b, 1'b1, 1'b0, ST_OK, payload_count());
          if (count >= payload_count()) begin
            phase = PH_CHECKSUM;
            count = '0;
          end
        end
        default: begin
          if (count == 16'd0) begin
            sum_low = b;
            count   = 16'd1;
          end else begin
            if ({b, sum_low} != sum)
              push_result(8'd0, 1'b0, 1'b1, ST_CHECKSUM, payload_count());
            else if (header[55:48] != 8'd0)
              push_result(8'd0, 1'b0, 1'b1, ST_DEVICE, payload_count());
            else
              push_result(8'd0, 1'b0, 1'b1, ST_OK, payload_count());
            end_frame();
          end
        end
      endcase
    endfunction

    function string to_text(frame_result_t r);
      return $sformatf("byte=%h pv=%b done=%b kind=%b st=%0d ret=%h cmd=%h src=%h dst=%h len=%0d",
                       r.payload_byte, r.payload_valid, r.frame_done, r.frame_kind, r.status,
                       r.return_code, r.command_code, r.source_id, r.dest_id,
                       r.payload_length);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: %s", to_text(got));
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch expected: %s", to_text(want));
          $display("         actual:   %s", to_text(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        frame_done;
  logic        frame_kind;
  logic [2:0]  status;
  logic [15:0] return_code;
  logic [15:0] command_code;
  logic [7:0]  source_id;
  logic [7:0]  dest_id;
  logic [9:0]  payload_length;

  frame_scoreboard sb;
  bit              idle_on = 1'b1;
  int unsigned     bytes_sent = 0;
  int unsigned     cycles = 0;
  int              stall_left = 0;
  logic [7:0]      frame_q[$];

  always #10 clk = ~clk;

  sensor_response_frame_receiver dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .payload_byte_o   (payload_byte),
    .payload_valid_o  (payload_valid),
    .frame_done_o     (frame_done),
    .frame_kind_o     (frame_kind),
    .status_o         (status),
    .return_code_o    (return_code),
    .command_code_o   (command_code),
    .source_id_o      (source_id),
    .dest_id_o        (dest_id),
    .payload_length_o (payload_length)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side starts random stall bursts only while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result({payload_byte, payload_valid, frame_done, frame_kind, status,
                         return_code, command_code, source_id, dest_id, payload_length});
      if (in_valid && !in_stall)
        sb.note_byte(rx_byte);
    end
  end

  function logic [7:0] prefix_byte();
    case ($urandom_range(0, 3))
      0: return PFX_RESP_0;
      1: return PFX_RESP_1;
      2: return PFX_DATA_0;
      default: return PFX_DATA_1;
    endcase
  endfunction

  task send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // cut < 0 sends the whole frame, otherwise only its first cut bytes
  task send_frame(input logic k, input logic [7:0] src, input logic [7:0] dst,
                  input logic [15:0] cmd, input logic [15:0] len, input logic [15:0] ret,
                  input bit bad_sum, input int cut);
    logic [15:0] sum;
    logic [7:0]  pb;
    int          n;
    frame_q.delete();
    frame_q.push_back(k == KIND_DATA ? PFX_DATA_0 : PFX_RESP_0);
    frame_q.push_back(k == KIND_DATA ? PFX_DATA_1 : PFX_RESP_1);
    frame_q.push_back(src);
    frame_q.push_back(dst);
    frame_q.push_back(cmd[7:0]);
    frame_q.push_back(cmd[15:8]);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(ret[7:0]);
    frame_q.push_back(ret[15:8]);
    sum = SUM_INIT;
    for (int i = 2; i < 10; i++) sum = sum + frame_q[i];
    if (k == KIND_RESP) n = RESP_DATA_BYTES;
    else if (len >= 16'd2 && int'(len) <= FRAME_BUF_BYTES) n = int'(len) - 2;
    else n = -1;
    if (n >= 0) begin
      repeat (n) begin
        pb = ($urandom_range(0, 7) == 0) ? prefix_byte() : 8'($urandom_range(0, 255));
        frame_q.push_back(pb);
        sum = sum + pb;
      end
      if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
      frame_q.push_back(sum[7:0]);
      frame_q.push_back(sum[15:8]);
    end
    if (cut >= 0)
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task random_frame();
    logic        k;
    logic [15:0] cmd;
    logic [15:0] len;
    logic [15:0] ret;
    int          sel;
    bit          bad;
    int          cut;
    k = 1'($urandom_range(0, 1));
    if (sb.expected_code != 16'd0 && $urandom_range(0, 3) != 0) cmd = sb.expected_code;
    else cmd = 16'($urandom_range(0, 65535));
    sel = $urandom_range(0, 199);
    if (sel < 170) len = 16'($urandom_range(2, 24));
    else if (sel < 186) len = 16'($urandom_range(25, 300));
    else if (sel < 187) len = 16'($urandom_range(1000, 1024));
    else if (sel < 193) len = 16'($urandom_range(0, 1));
    else len = 16'($urandom_range(1025, 65535));
    if ($urandom_range(0, 2) == 0) ret = 16'($urandom_range(0, 65535));
    else ret = {8'($urandom_range(0, 255)), 8'h00};
    bad = ($urandom_range(0, 6) == 0);
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : -1;
    send_frame(k, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cmd, len, ret,
               bad, cut);
  endtask

  task run_phase(input int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6))
          send_byte(($urandom_range(0, 2) == 0) ? prefix_byte() : 8'($urandom_range(0, 255)));
      end else begin
        random_frame();
      end
    end
  endtask

  // header bytes give no result, so the wait goes on past the last result
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0 || out_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_code(input logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.expected_code = value;
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_code(16'h0000);
    send_frame(KIND_RESP, 8'h00, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, -1);
    send_frame(KIND_DATA, 8'hFF, 8'h00, 16'hFFFF, 16'd2, 16'hFF00, 1'b0, -1);
    send_frame(KIND_DATA, 8'h12, 8'h34, 16'h0101, 16'd0, 16'h0000, 1'b0, -1);
    send_frame(KIND_DATA, 8'h12, 8'h34, 16'h0101, 16'd1, 16'h0000, 1'b0, -1);
    send_frame(KIND_DATA, 8'h12, 8'h34, 16'h0101, 16'd1025, 16'h0000, 1'b0, -1);
    send_frame(KIND_DATA, 8'h12, 8'h34, 16'h0101, 16'hFFFF, 16'h0000, 1'b0, -1);
    send_frame(KIND_DATA, 8'hA5, 8'h5A, 16'h8000, 16'd30, 16'h0000, 1'b0, -1);
    // checksum error beats device error
    send_frame(KIND_RESP, 8'h01, 8'h02, 16'h0010, 16'h0000, 16'h0001, 1'b1, -1);
    send_frame(KIND_RESP, 8'h01, 8'h02, 16'h0010, 16'h0000, 16'h00FF, 1'b0, -1);
    send_frame(KIND_DATA, 8'h03, 8'h04, 16'h0020, 16'd6, 16'h0000, 1'b1, -1);
    // prefix resync cases
    send_byte(PFX_RESP_0);
    send_frame(KIND_RESP, 8'h05, 8'h06, 16'h0030, 16'h0000, 16'h0000, 1'b0, -1);
    send_byte(PFX_DATA_0);
    send_frame(KIND_RESP, 8'h07, 8'h08, 16'h0040, 16'h0000, 16'h0000, 1'b0, -1);
    send_byte(PFX_RESP_0);
    send_frame(KIND_DATA, 8'h09, 8'h0A, 16'h0050, 16'd5, 16'h0000, 1'b0, -1);
    send_byte(PFX_RESP_0);
    send_byte(8'h00);
    send_frame(KIND_DATA, 8'h0B, 8'h0C, 16'h0060, 16'd3, 16'h0000, 1'b0, -1);

    write_code(16'hFFFF);
    // code mismatch wins over bad length
    send_frame(KIND_DATA, 8'h11, 8'h22, 16'h1234, 16'd0, 16'h0000, 1'b0, -1);
    send_frame(KIND_RESP, 8'h33, 8'h44, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, -1);
    send_frame(KIND_RESP, 8'h33, 8'h44, 16'hFFFE, 16'h0000, 16'h0000, 1'b0, -1);

    write_code(16'h0000);
    run_phase(40);
    write_code(16'($urandom_range(1, 65535)));
    run_phase(40);
    write_code(16'h0001);
    run_phase(40);
    write_code(16'h0000);
    idle_on = 1'b0;
    run_phase(40);

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
